// ===== hdl/sd_spi_mode_host_sequencer_macros.svh =====
// Assertion macros used by the SD SPI-mode host sequencer core.
`ifndef SD_SPI_MODE_HOST_SEQUENCER_MACROS_SVH
`define SD_SPI_MODE_HOST_SEQUENCER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define SDSPI_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sd spi sequencer: implication check failed");
// Next-cycle implication, disabled during reset.
`define SDSPI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sd spi sequencer: next-cycle check failed");
`else
`define SDSPI_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define SDSPI_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/sdspi_pkg.sv =====
// Types, codes and helper functions of the SD SPI-mode host sequencer.
`timescale 1ns / 1ps
package sdspi_pkg;

   localparam int unsigned BLOCK_BYTES   = 512;
   localparam int unsigned WAKE_BYTES_DEF = 10;

   localparam logic [1:0] FUNC_REQ   = 2'd0;
   localparam logic [1:0] FUNC_MISO  = 2'd1;
   localparam logic [1:0] FUNC_WDATA = 2'd2;

   localparam logic [1:0] REQ_INIT  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;

   localparam logic [2:0] CSR_READY_TO  = 3'd0;
   localparam logic [2:0] CSR_TOKEN_TO  = 3'd1;
   localparam logic [2:0] CSR_POLLS     = 3'd2;
   localparam logic [2:0] CSR_IDLE_RET  = 3'd3;
   localparam logic [2:0] CSR_OP_RET    = 3'd4;

   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_BUSY_TO  = 3'd1;
   localparam logic [2:0] STAT_CMD_ERR  = 3'd2;
   localparam logic [2:0] STAT_TOKEN_TO = 3'd3;
   localparam logic [2:0] STAT_WR_REJ   = 3'd4;

   localparam logic [2:0] CARD_NONE = 3'd0;
   localparam logic [2:0] CARD_MMC  = 3'd1;
   localparam logic [2:0] CARD_SD1  = 3'd2;
   localparam logic [2:0] CARD_SD2  = 3'd3;
   localparam logic [2:0] CARD_SDHC = 3'd4;

   localparam logic [7:0] BYTE_IDLE   = 8'hFF;
   localparam logic [7:0] TOK_START   = 8'hFE;
   localparam logic [7:0] TOK_MULTI   = 8'hFC;
   localparam logic [7:0] TOK_STOP    = 8'hFD;
   localparam logic [7:0] CRC_CMD0    = 8'h95;
   localparam logic [7:0] CRC_CMD8    = 8'h87;
   localparam logic [7:0] CRC_DUMMY   = 8'h01;
   localparam logic [7:0] R1_IDLE     = 8'h01;
   localparam logic [7:0] R7_PATTERN  = 8'hAA;
   localparam logic [4:0] DRESP_MASK  = 5'h1F;
   localparam logic [4:0] DRESP_OK    = 5'h05;
   localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
   localparam logic [31:0] ARG_HCS     = 32'h4000_0000;

   localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
   localparam logic [5:0] CMD_SEND_OP   = 6'd1;
   localparam logic [5:0] CMD_IF_COND   = 6'd8;
   localparam logic [5:0] CMD_STOP      = 6'd12;
   localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
   localparam logic [5:0] CMD_READ_ONE  = 6'd17;
   localparam logic [5:0] CMD_READ_MUL  = 6'd18;
   localparam logic [5:0] CMD_SET_COUNT = 6'd23;
   localparam logic [5:0] CMD_WRITE_ONE = 6'd24;
   localparam logic [5:0] CMD_WRITE_MUL = 6'd25;
   localparam logic [5:0] CMD_SD_OP     = 6'd41;
   localparam logic [5:0] CMD_APP       = 6'd55;
   localparam logic [5:0] CMD_READ_OCR  = 6'd58;

   typedef enum logic [17:0] {
      PH_IDLE    = 18'd1 << 0,
      PH_WAKE    = 18'd1 << 1,
      PH_DESEL   = 18'd1 << 2,
      PH_READY   = 18'd1 << 3,
      PH_SELFAIL = 18'd1 << 4,
      PH_CMDB    = 18'd1 << 5,
      PH_R1      = 18'd1 << 6,
      PH_TRAIL   = 18'd1 << 7,
      PH_TOKEN   = 18'd1 << 8,
      PH_RDATA   = 18'd1 << 9,
      PH_RCRC    = 18'd1 << 10,
      PH_WREADY  = 18'd1 << 11,
      PH_WTOKEN  = 18'd1 << 12,
      PH_WNEED   = 18'd1 << 13,
      PH_WDATA   = 18'd1 << 14,
      PH_WCRC    = 18'd1 << 15,
      PH_WRESP   = 18'd1 << 16,
      PH_FINAL   = 18'd1 << 17
   } phase_type;

   typedef enum logic [22:0] {
      STG_NONE    = 23'd1 << 0,
      STG_CMD0    = 23'd1 << 1,
      STG_CMD8    = 23'd1 << 2,
      STG_R7      = 23'd1 << 3,
      STG_V2_55   = 23'd1 << 4,
      STG_V2_41   = 23'd1 << 5,
      STG_CMD58   = 23'd1 << 6,
      STG_OCR     = 23'd1 << 7,
      STG_V1_55A  = 23'd1 << 8,
      STG_V1_41A  = 23'd1 << 9,
      STG_V1_55   = 23'd1 << 10,
      STG_V1_41   = 23'd1 << 11,
      STG_MMC1    = 23'd1 << 12,
      STG_CMD16   = 23'd1 << 13,
      STG_CMD17   = 23'd1 << 14,
      STG_CMD18   = 23'd1 << 15,
      STG_RBLK    = 23'd1 << 16,
      STG_CMD12   = 23'd1 << 17,
      STG_CMD24   = 23'd1 << 18,
      STG_W55     = 23'd1 << 19,
      STG_W23     = 23'd1 << 20,
      STG_CMD25   = 23'd1 << 21,
      STG_WBLK    = 23'd1 << 22
   } stage_type;

   typedef struct packed {
      logic [7:0] mosi_byte;
      logic       mosi_valid;
      logic       chip_select_n;
      logic       slow_clock;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       need_write_byte;
      logic       done_res;
      logic [2:0] status;
      logic [2:0] card_kind;
   } rsp_type;

   // Byte k of the six-byte command frame; anything past the CRC is a stuff byte.
   function automatic logic [7:0] frame_byte(input logic [5:0] idx, input logic [31:0] arg,
                                             input logic [2:0] k);
      logic [7:0] b;
      case (k)
         3'd0: b = {2'b01, idx};
         3'd1: b = arg[31:24];
         3'd2: b = arg[23:16];
         3'd3: b = arg[15:8];
         3'd4: b = arg[7:0];
         3'd5: b = (idx == CMD_GO_IDLE) ? CRC_CMD0 :
                   ((idx == CMD_IF_COND) ? CRC_CMD8 : CRC_DUMMY);
         default: b = BYTE_IDLE;
      endcase
      return b;
   endfunction

endpackage

// ===== hdl/sd_spi_mode_host_sequencer.sv =====
// Top level of the SD SPI-mode host sequencer.
`timescale 1ns / 1ps
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | func, request, sector, count, miso/write byte
//  rsp     | out       | rsp_valid/rsp_ready  | mosi, chip select, clock speed, read data, done
//  csr     | in        | csr_we (no wait)     | csr_index, csr_wdata
//
//  Each accepted request transfer updates the sequencer state and the result register at
//  the same edge, so one transfer per cycle is sustained while the result register has room.
//  A result that waits in the output register does not block input while rsp_ready is
//  high; with rsp_ready low and a result held, req_ready drops until it is taken.
//  Ignored transfers (requests while busy, stray bytes) are accepted and yield no result.
//  Reset is synchronous: idle, card deselected, slow clock on, registers at defaults.
module sd_spi_mode_host_sequencer #(
   parameter int unsigned WAKE_BYTES = sdspi_pkg::WAKE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [1:0]  req_request,
   input  logic [31:0] req_sector,
   input  logic [7:0]  req_count,
   input  logic [7:0]  req_miso_byte,
   input  logic [7:0]  req_write_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_mosi_byte,
   output logic        rsp_mosi_valid,
   output logic        rsp_chip_select_n,
   output logic        rsp_slow_clock,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_read_valid,
   output logic        rsp_need_write_byte,
   output logic        rsp_done_res,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_card_kind,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import sdspi_pkg::*;

   logic    fire;
   logic    take;
   rsp_type core_rsp;
   rsp_type out_rsp;

   // A transfer is taken whenever the result register has room.
   assign fire = req_valid && req_ready;

   sdspi_core #(
      .WAKE_BYTES (WAKE_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .func       (req_func),
      .request    (req_request),
      .sector     (req_sector),
      .count      (req_count),
      .miso_byte  (req_miso_byte),
      .write_byte (req_write_byte),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .take       (take),
      .rsp        (core_rsp)
   );

   // Hold the result here so the next byte can enter while this one waits.
   sdspi_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (take),
      .data_in   (core_rsp),
      .up_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .data_out  (out_rsp)
   );

   assign rsp_mosi_byte       = out_rsp.mosi_byte;
   assign rsp_mosi_valid      = out_rsp.mosi_valid;
   assign rsp_chip_select_n   = out_rsp.chip_select_n;
   assign rsp_slow_clock      = out_rsp.slow_clock;
   assign rsp_read_byte       = out_rsp.read_byte;
   assign rsp_read_valid      = out_rsp.read_valid;
   assign rsp_need_write_byte = out_rsp.need_write_byte;
   assign rsp_done_res        = out_rsp.done_res;
   assign rsp_status          = out_rsp.status;
   assign rsp_card_kind       = out_rsp.card_kind;

endmodule

// ===== hdl/sdspi_core.sv =====
// Sequencer state, configuration registers and the per-transfer next-state logic.
`timescale 1ns / 1ps
`include "sd_spi_mode_host_sequencer_macros.svh"
module sdspi_core #(
   parameter int unsigned WAKE_BYTES = sdspi_pkg::WAKE_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [1:0]        func,
   input  logic [1:0]        request,
   input  logic [31:0]       sector,
   input  logic [7:0]        count,
   input  logic [7:0]        miso_byte,
   input  logic [7:0]        write_byte,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [23:0]       csr_wdata,
   output logic              take,
   output sdspi_pkg::rsp_type rsp
);
   import sdspi_pkg::*;

   typedef struct packed {
      phase_type   phase;
      stage_type   stage;
      logic [2:0]  card;
      logic [5:0]  cmd_idx;
      logic [31:0] cmd_arg;
      logic [23:0] rc;
      logic [9:0]  bc;
      logic [7:0]  sl;
      logic [7:0]  rb0;
      logic [7:0]  rb2;
      logic [31:0] target;
      logic [15:0] attempts;
      logic [1:0]  mode;
      logic        multi;
      logic [7:0]  wtoken;
      logic        cs;
      logic        slow;
      logic        sel_fail;
      logic [2:0]  err;
   } state_type;

   typedef enum logic [5:0] {
      ACT_NONE   = 6'd1 << 0,
      ACT_ISSUE  = 6'd1 << 1,
      ACT_FINISH = 6'd1 << 2,
      ACT_TRAIL  = 6'd1 << 3,
      ACT_AWAIT  = 6'd1 << 4,
      ACT_BEGIN  = 6'd1 << 5
   } act_type;

   state_type   s_ff, s_in;
   logic [23:0] ready_to_ff;
   logic [15:0] token_to_ff;
   logic [7:0]  polls_ff;
   logic [7:0]  idle_ret_ff;
   logic [15:0] op_ret_ff;

   act_type     act;
   logic [5:0]  a_idx;
   logic [31:0] a_arg;
   stage_type   a_stage;
   logic [7:0]  a_tok;
   logic        do_cmd;
   logic [7:0]  r_val;
   logic        do_rend, rend_ok, do_wend, wend_ok;
   logic [23:0] rc_inc;
   logic [10:0] bc_inc;
   logic [7:0]  sl_dec;
   logic [31:0] tgt;
   rsp_type     o;

   always_comb begin
      s_in    = s_ff;
      o       = '0;
      take    = 1'b0;
      act     = ACT_NONE;
      a_idx   = CMD_GO_IDLE;
      a_arg   = '0;
      a_stage = STG_NONE;
      a_tok   = TOK_START;
      do_cmd  = 1'b0;
      r_val   = BYTE_IDLE;
      do_rend = 1'b0;
      rend_ok = 1'b0;
      do_wend = 1'b0;
      wend_ok = 1'b0;
      rc_inc  = s_ff.rc + 24'd1;
      bc_inc  = {1'b0, s_ff.bc} + 11'd1;
      sl_dec  = s_ff.sl - 8'd1;
      tgt     = (s_ff.card == CARD_SDHC) ? sector : {sector[22:0], 9'd0};

      if (fire) begin
         case (func)
            FUNC_REQ: begin
               if (s_ff.phase == PH_IDLE && request != 2'd3) begin
                  take          = 1'b1;
                  s_in.err      = STAT_OK;
                  s_in.sel_fail = 1'b0;
                  s_in.mode     = request;
                  if (request == REQ_INIT) begin
                     s_in.multi = 1'b0;
                     s_in.card  = CARD_NONE;
                     s_in.slow  = 1'b1;
                     s_in.cs    = 1'b1;
                     s_in.bc    = '0;
                     o.mosi_byte  = BYTE_IDLE;
                     o.mosi_valid = 1'b1;
                     s_in.phase = PH_WAKE;
                  end else begin
                     s_in.sl     = count;
                     s_in.multi  = (count != 8'd1);
                     s_in.target = tgt;
                     act = ACT_ISSUE;
                     a_arg = tgt;
                     if (request == REQ_READ) begin
                        a_idx   = (count != 8'd1) ? CMD_READ_MUL : CMD_READ_ONE;
                        a_stage = (count != 8'd1) ? STG_CMD18 : STG_CMD17;
                     end else if (count == 8'd1) begin
                        a_idx   = CMD_WRITE_ONE;
                        a_stage = STG_CMD24;
                     end else if (s_ff.card != CARD_MMC) begin
                        a_idx   = CMD_APP;
                        a_arg   = '0;
                        a_stage = STG_W55;
                     end else begin
                        a_idx   = CMD_WRITE_MUL;
                        a_stage = STG_CMD25;
                     end
                  end
               end
            end
            FUNC_MISO: begin
               if (s_ff.phase != PH_IDLE && s_ff.phase != PH_WNEED) begin
                  take = 1'b1;
                  case (s_ff.phase)
                     PH_WAKE: begin
                        s_in.bc = bc_inc[9:0];
                        if (bc_inc < 11'(WAKE_BYTES)) begin
                           o.mosi_byte  = BYTE_IDLE;
                           o.mosi_valid = 1'b1;
                        end else begin
                           s_in.attempts = {8'd0, idle_ret_ff};
                           act     = ACT_ISSUE;
                           a_idx   = CMD_GO_IDLE;
                           a_stage = STG_CMD0;
                        end
                     end
                     PH_DESEL: begin
                        s_in.cs = 1'b0;
                        s_in.rc = '0;
                        o.mosi_byte  = BYTE_IDLE;
                        o.mosi_valid = 1'b1;
                        s_in.phase = PH_READY;
                     end
                     PH_READY: begin
                        o.mosi_valid = 1'b1;
                        if (miso_byte == BYTE_IDLE) begin
                           s_in.bc = '0;
                           o.mosi_byte = frame_byte(s_ff.cmd_idx, s_ff.cmd_arg, 3'd0);
                           s_in.phase = PH_CMDB;
                        end else begin
                           s_in.rc = rc_inc;
                           o.mosi_byte = BYTE_IDLE;
                           if (rc_inc >= ready_to_ff) begin
                              s_in.cs = 1'b1;
                              s_in.phase = PH_SELFAIL;
                           end
                        end
                     end
                     PH_SELFAIL: begin
                        s_in.sel_fail = 1'b1;
                        do_cmd = 1'b1;
                        r_val  = BYTE_IDLE;
                     end
                     PH_CMDB: begin
                        s_in.bc = bc_inc[9:0];
                        o.mosi_valid = 1'b1;
                        if (bc_inc < ((s_ff.cmd_idx == CMD_STOP) ? 11'd7 : 11'd6)) begin
                           o.mosi_byte = frame_byte(s_ff.cmd_idx, s_ff.cmd_arg, bc_inc[2:0]);
                        end else begin
                           s_in.bc = '0;
                           o.mosi_byte = BYTE_IDLE;
                           s_in.phase = PH_R1;
                        end
                     end
                     PH_R1: begin
                        if (miso_byte[7] && s_ff.bc < {2'b00, polls_ff}) begin
                           s_in.bc = bc_inc[9:0];
                           o.mosi_byte  = BYTE_IDLE;
                           o.mosi_valid = 1'b1;
                        end else begin
                           s_in.sel_fail = 1'b0;
                           do_cmd = 1'b1;
                           r_val  = miso_byte;
                        end
                     end
                     PH_TRAIL: begin
                        if (s_ff.bc[1:0] == 2'd0) s_in.rb0 = miso_byte;
                        if (s_ff.bc[1:0] == 2'd2) s_in.rb2 = miso_byte;
                        s_in.bc = bc_inc[9:0];
                        if (bc_inc >= 11'd4) begin
                           if (s_ff.stage == STG_R7) begin
                              if (s_ff.rb2 == R1_IDLE && miso_byte == R7_PATTERN) begin
                                 s_in.attempts = op_ret_ff;
                                 act     = ACT_ISSUE;
                                 a_idx   = CMD_APP;
                                 a_stage = STG_V2_55;
                              end else begin
                                 if (s_in.err == STAT_OK) s_in.err = STAT_CMD_ERR;
                                 act = ACT_FINISH;
                              end
                           end else begin
                              s_in.card = s_ff.rb0[6] ? CARD_SDHC : CARD_SD2;
                              act = ACT_FINISH;
                           end
                        end else begin
                           o.mosi_byte  = BYTE_IDLE;
                           o.mosi_valid = 1'b1;
                        end
                     end
                     PH_TOKEN: begin
                        if (miso_byte == TOK_START) begin
                           s_in.bc = '0;
                           o.mosi_byte  = BYTE_IDLE;
                           o.mosi_valid = 1'b1;
                           s_in.phase = PH_RDATA;
                        end else begin
                           s_in.rc = rc_inc;
                           if (rc_inc >= {8'd0, token_to_ff}) begin
                              if (s_in.err == STAT_OK) s_in.err = STAT_TOKEN_TO;
                              do_rend = 1'b1;
                           end else begin
                              o.mosi_byte  = BYTE_IDLE;
                              o.mosi_valid = 1'b1;
                           end
                        end
                     end
                     PH_RDATA: begin
                        o.read_byte  = miso_byte;
                        o.read_valid = 1'b1;
                        s_in.bc = bc_inc[9:0];
                        if (bc_inc >= 11'(BLOCK_BYTES)) begin
                           s_in.bc = '0;
                           s_in.phase = PH_RCRC;
                        end
                        o.mosi_byte  = BYTE_IDLE;
                        o.mosi_valid = 1'b1;
                     end
                     PH_RCRC: begin
                        s_in.bc = bc_inc[9:0];
                        if (bc_inc >= 11'd2) begin
                           do_rend = 1'b1;
                           rend_ok = 1'b1;
                        end else begin
                           o.mosi_byte  = BYTE_IDLE;
                           o.mosi_valid = 1'b1;
                        end
                     end
                     PH_WREADY: begin
                        if (miso_byte == BYTE_IDLE) begin
                           o.mosi_byte  = s_ff.wtoken;
                           o.mosi_valid = 1'b1;
                           s_in.phase = PH_WTOKEN;
                        end else begin
                           s_in.rc = rc_inc;
                           if (rc_inc >= ready_to_ff) begin
                              if (s_in.err == STAT_OK) s_in.err = STAT_BUSY_TO;
                              do_wend = 1'b1;
                           end else begin
                              o.mosi_byte  = BYTE_IDLE;
                              o.mosi_valid = 1'b1;
                           end
                        end
                     end
                     PH_WTOKEN: begin
                        if (s_ff.wtoken == TOK_STOP) begin
                           act = ACT_FINISH;
                        end else begin
                           s_in.bc = '0;
                           o.need_write_byte = 1'b1;
                           s_in.phase = PH_WNEED;
                        end
                     end
                     PH_WDATA: begin
                        s_in.bc = bc_inc[9:0];
                        if (bc_inc < 11'(BLOCK_BYTES)) begin
                           o.need_write_byte = 1'b1;
                           s_in.phase = PH_WNEED;
                        end else begin
                           s_in.bc = '0;
                           o.mosi_byte  = BYTE_IDLE;
                           o.mosi_valid = 1'b1;
                           s_in.phase = PH_WCRC;
                        end
                     end
                     PH_WCRC: begin
                        s_in.bc = bc_inc[9:0];
                        if (bc_inc >= 11'd2) s_in.phase = PH_WRESP;
                        o.mosi_byte  = BYTE_IDLE;
                        o.mosi_valid = 1'b1;
                     end
                     PH_WRESP: begin
                        do_wend = 1'b1;
                        wend_ok = ((miso_byte[4:0] & DRESP_MASK) == DRESP_OK);
                        if (!wend_ok && s_in.err == STAT_OK) s_in.err = STAT_WR_REJ;
                     end
                     PH_FINAL: begin
                        if (s_ff.mode == REQ_INIT) begin
                           s_in.slow = 1'b0;
                           o.status = (s_ff.card != CARD_NONE) ? STAT_OK :
                                      ((s_ff.err != STAT_OK) ? s_ff.err : STAT_CMD_ERR);
                        end else begin
                           o.status = s_ff.err;
                        end
                        o.done_res = 1'b1;
                        s_in.phase = PH_IDLE;
                     end
                     default: s_in.phase = PH_IDLE;
                  endcase
               end
            end
            FUNC_WDATA: begin
               if (s_ff.phase == PH_WNEED) begin
                  take = 1'b1;
                  o.mosi_byte  = write_byte;
                  o.mosi_valid = 1'b1;
                  s_in.phase = PH_WDATA;
               end
            end
            default: take = 1'b0;
         endcase
      end

      // Resolve the R1 answer of the command that just ended.
      if (do_cmd) begin
         act = ACT_ISSUE;
         case (s_ff.stage)
            STG_CMD0: begin
               if (r_val == R1_IDLE) begin
                  a_idx = CMD_IF_COND; a_arg = ARG_IF_COND; a_stage = STG_CMD8;
               end else if (s_ff.attempts != 16'd0) begin
                  s_in.attempts = s_ff.attempts - 16'd1;
                  a_idx = CMD_GO_IDLE; a_stage = STG_CMD0;
               end else begin
                  if (s_in.err == STAT_OK)
                     s_in.err = s_in.sel_fail ? STAT_BUSY_TO : STAT_CMD_ERR;
                  act = ACT_FINISH;
               end
            end
            STG_CMD8: begin
               if (r_val == R1_IDLE) begin
                  act = ACT_TRAIL; a_stage = STG_R7;
               end else begin
                  a_idx = CMD_APP; a_stage = STG_V1_55A;
               end
            end
            STG_V2_55: begin
               a_idx = CMD_SD_OP; a_arg = ARG_HCS; a_stage = STG_V2_41;
            end
            STG_V2_41: begin
               if (r_val == 8'd0) begin
                  a_idx = CMD_READ_OCR; a_stage = STG_CMD58;
               end else if (s_ff.attempts != 16'd0) begin
                  s_in.attempts = s_ff.attempts - 16'd1;
                  a_idx = CMD_APP; a_stage = STG_V2_55;
               end else begin
                  if (s_in.err == STAT_OK)
                     s_in.err = s_in.sel_fail ? STAT_BUSY_TO : STAT_CMD_ERR;
                  act = ACT_FINISH;
               end
            end
            STG_CMD58: begin
               if (r_val == 8'd0) begin
                  act = ACT_TRAIL; a_stage = STG_OCR;
               end else begin
                  if (s_in.err == STAT_OK)
                     s_in.err = s_in.sel_fail ? STAT_BUSY_TO : STAT_CMD_ERR;
                  act = ACT_FINISH;
               end
            end
            STG_V1_55A: begin
               a_idx = CMD_SD_OP; a_stage = STG_V1_41A;
            end
            STG_V1_41A: begin
               s_in.attempts = op_ret_ff;
               if (r_val <= 8'd1) begin
                  s_in.card = CARD_SD1; a_idx = CMD_APP; a_stage = STG_V1_55;
               end else begin
                  s_in.card = CARD_MMC; a_idx = CMD_SEND_OP; a_stage = STG_MMC1;
               end
            end
            STG_V1_55: begin
               a_idx = CMD_SD_OP; a_stage = STG_V1_41;
            end
            STG_V1_41, STG_MMC1: begin
               if (r_val == 8'd0) begin
                  a_idx = CMD_BLOCKLEN; a_arg = 32'(BLOCK_BYTES); a_stage = STG_CMD16;
               end else if (s_ff.attempts != 16'd0) begin
                  s_in.attempts = s_ff.attempts - 16'd1;
                  if (s_ff.stage == STG_MMC1) begin
                     a_idx = CMD_SEND_OP; a_stage = STG_MMC1;
                  end else begin
                     a_idx = CMD_APP; a_stage = STG_V1_55;
                  end
               end else begin
                  s_in.card = CARD_NONE;
                  if (s_in.err == STAT_OK)
                     s_in.err = s_in.sel_fail ? STAT_BUSY_TO : STAT_CMD_ERR;
                  act = ACT_FINISH;
               end
            end
            STG_CMD16: begin
               if (r_val != 8'd0) begin
                  s_in.card = CARD_NONE;
                  if (s_in.err == STAT_OK)
                     s_in.err = s_in.sel_fail ? STAT_BUSY_TO : STAT_CMD_ERR;
               end
               act = ACT_FINISH;
            end
            STG_CMD17, STG_CMD18: begin
               if (r_val == 8'd0) begin
                  act = ACT_AWAIT;
               end else begin
                  if (s_in.err == STAT_OK)
                     s_in.err = s_in.sel_fail ? STAT_BUSY_TO : STAT_CMD_ERR;
                  act = ACT_FINISH;
               end
            end
            STG_W55: begin
               a_idx = CMD_SET_COUNT; a_arg = {24'd0, s_ff.sl}; a_stage = STG_W23;
            end
            STG_W23: begin
               a_idx = CMD_WRITE_MUL; a_arg = s_ff.target; a_stage = STG_CMD25;
            end
            STG_CMD24, STG_CMD25: begin
               if (r_val == 8'd0) begin
                  act = ACT_BEGIN;
                  a_tok = (s_ff.stage == STG_CMD24) ? TOK_START : TOK_MULTI;
               end else begin
                  if (s_in.err == STAT_OK)
                     s_in.err = s_in.sel_fail ? STAT_BUSY_TO : STAT_CMD_ERR;
                  act = ACT_FINISH;
               end
            end
            default: act = ACT_FINISH;
         endcase
      end

      // End of a read block: next token, stop command or done.
      if (do_rend) begin
         if (!s_ff.multi) begin
            act = ACT_FINISH;
         end else begin
            s_in.sl = sl_dec;
            if (rend_ok && sl_dec != 8'd0) begin
               act = ACT_AWAIT;
            end else begin
               act = ACT_ISSUE; a_idx = CMD_STOP; a_arg = '0; a_stage = STG_CMD12;
            end
         end
      end

      // End of a write block: next block, stop token or done.
      if (do_wend) begin
         if (!s_ff.multi || s_ff.wtoken == TOK_STOP) begin
            act = ACT_FINISH;
         end else begin
            s_in.sl = sl_dec;
            act   = ACT_BEGIN;
            a_tok = (wend_ok && sl_dec != 8'd0) ? TOK_MULTI : TOK_STOP;
         end
      end

      case (act)
         ACT_ISSUE: begin
            s_in.cmd_idx = a_idx;
            s_in.cmd_arg = a_arg;
            s_in.stage   = a_stage;
            s_in.cs      = 1'b1;
            s_in.phase   = PH_DESEL;
         end
         ACT_FINISH: begin
            s_in.cs    = 1'b1;
            s_in.phase = PH_FINAL;
         end
         ACT_TRAIL: begin
            s_in.stage = a_stage;
            s_in.bc    = '0;
            s_in.phase = PH_TRAIL;
         end
         ACT_AWAIT: begin
            s_in.stage = STG_RBLK;
            s_in.rc    = '0;
            s_in.phase = PH_TOKEN;
         end
         ACT_BEGIN: begin
            s_in.wtoken = a_tok;
            s_in.stage  = STG_WBLK;
            s_in.rc     = '0;
            s_in.phase  = PH_WREADY;
         end
         default: s_in.wtoken = s_in.wtoken;
      endcase
      if (act != ACT_NONE) begin
         o.mosi_byte  = BYTE_IDLE;
         o.mosi_valid = 1'b1;
      end

      o.chip_select_n = s_in.cs;
      o.slow_clock    = s_in.slow;
      o.card_kind     = s_in.card;
   end

   assign rsp = o;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff.phase    <= PH_IDLE;
         s_ff.stage    <= STG_NONE;
         s_ff.card     <= CARD_NONE;
         s_ff.cmd_idx  <= '0;
         s_ff.cmd_arg  <= '0;
         s_ff.rc       <= '0;
         s_ff.bc       <= '0;
         s_ff.sl       <= '0;
         s_ff.rb0      <= '0;
         s_ff.rb2      <= '0;
         s_ff.target   <= '0;
         s_ff.attempts <= '0;
         s_ff.mode     <= REQ_INIT;
         s_ff.multi    <= 1'b0;
         s_ff.wtoken   <= '0;
         s_ff.cs       <= 1'b1;
         s_ff.slow     <= 1'b1;
         s_ff.sel_fail <= 1'b0;
         s_ff.err      <= STAT_OK;
      end else begin
         s_ff <= s_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_to_ff <= 24'hFF_FFFF;
         token_to_ff <= 16'hFFFF;
         polls_ff    <= 8'd31;
         idle_ret_ff <= 8'd20;
         op_ret_ff   <= 16'd65534;
      end else if (csr_we) begin
         case (csr_index)
            CSR_READY_TO: ready_to_ff <= csr_wdata;
            CSR_TOKEN_TO: token_to_ff <= csr_wdata[15:0];
            CSR_POLLS:    polls_ff    <= csr_wdata[7:0];
            CSR_IDLE_RET: idle_ret_ff <= csr_wdata[7:0];
            CSR_OP_RET:   op_ret_ff   <= csr_wdata[15:0];
            default:      polls_ff    <= polls_ff;
         endcase
      end
   end

   `SDSPI_ASSERT_IMPLY(a_idle_deselected, clock, reset, s_ff.phase == PH_IDLE, s_ff.cs)
   `SDSPI_ASSERT_NEXT(a_done_goes_idle, clock, reset, take && o.done_res, s_ff.phase == PH_IDLE)
   `SDSPI_ASSERT_NEXT(a_wdata_follows, clock, reset,
      fire && func == FUNC_WDATA && s_ff.phase == PH_WNEED, s_ff.phase == PH_WDATA)
   `SDSPI_ASSERT_IMPLY(a_no_send_and_need, clock, reset, take,
      !(o.mosi_valid && o.need_write_byte))

endmodule

// ===== hdl/sdspi_rsp_reg.sv =====
// Result register that holds one result transfer until the consumer takes it.
`timescale 1ns / 1ps
module sdspi_rsp_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  sdspi_pkg::rsp_type data_in,
   output logic               up_ready,
   output logic               out_valid,
   input  logic               out_ready,
   output sdspi_pkg::rsp_type data_out
);
   import sdspi_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   assign up_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign data_out  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load && up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule
